@@ rtl/dnsar_pkg.sv @@
// Package for the DNS A-record response parser.
// Holds the parse phase type, status codes, result struct and constants.
// No dependencies; dnsar_core and the top level import it.
package dnsar_pkg;

  // Parse phase of the packet currently being received.
  typedef enum logic [2:0] {
    PH_HEADER,
    PH_QNAME,
    PH_QTAIL,
    PH_ANSWER,
    PH_RDATA,
    PH_FOUND,
    PH_ZERO,
    PH_BADREC
  } phase_t;

  typedef logic [2:0] status_t;

  // Result status codes.
  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_WRONG_PORT = 3'd1;
  localparam status_t ST_SHORT_HDR  = 3'd2;
  localparam status_t ST_ZERO_COUNT = 3'd3;
  localparam status_t ST_TRUNCATED  = 3'd4;
  localparam status_t ST_BAD_RECORD = 3'd5;

  // Byte positions that close each fixed-length section.
  localparam logic [3:0] HEADER_LAST = 4'd11;
  localparam logic [3:0] QTAIL_LAST  = 4'd3;
  localparam logic [3:0] ANSWER_LAST = 4'd11;
  localparam logic [3:0] RDATA_LAST  = 4'd3;

  // Reset value of the server port register.
  localparam logic [15:0] SERVER_PORT_RST = 16'd53;

  // One result transaction.
  typedef struct packed {
    logic        found;
    logic [31:0] address;
    status_t     status;
  } result_t;

endpackage

@@ rtl/dnsar_in_if.sv @@
// Input channel of the DNS A-record parser: one payload byte per transaction.
// Plain valid/ready handshake; no dependencies.
interface dnsar_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [15:0] source_port;
  logic        last;

  modport source (output valid, data_byte, source_port, last, input ready);
  modport sink   (input valid, data_byte, source_port, last, output ready);
endinterface

@@ rtl/dnsar_out_if.sv @@
// Result channel of the DNS A-record parser: one transaction per packet.
// Plain valid/ready handshake; no dependencies.
interface dnsar_out_if;
  logic        valid;
  logic        ready;
  logic        found;
  logic [31:0] address;
  logic [2:0]  status;

  modport source (output valid, found, address, status, input ready);
  modport sink   (input valid, found, address, status, output ready);
endinterface

@@ rtl/dnsar_cfg_if.sv @@
// Configuration write channel of the DNS A-record parser.
// Carries the server port register value; no dependencies.
interface dnsar_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] server_port;

  modport source (output valid, server_port, input ready);
  modport sink   (input valid, server_port, output ready);
endinterface

@@ rtl/dnsar_core.sv @@
// Parse state machine of the DNS A-record parser: one byte per cycle while step is high.
// Depends on dnsar_pkg; produces the result of a packet on its final byte.
module dnsar_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [7:0]        data_byte,
  input  logic [15:0]       source_port,
  input  logic              last,
  input  logic [15:0]       server_port,
  output dnsar_pkg::result_t res
);
  import dnsar_pkg::*;

  phase_t      phase_r, phase_upd, phase_nxt;
  logic [3:0]  idx_r, idx_upd, idx_nxt;
  logic [15:0] qcount_r, qcount_upd, qcount_nxt;
  logic [15:0] acount_r, acount_upd, acount_nxt;
  logic [15:0] qleft_r, qleft_upd, qleft_nxt;
  logic        fields_ok_r, fields_ok_upd, fields_ok_nxt;
  logic [31:0] addr_r, addr_upd, addr_nxt;
  logic        mismatch;
  logic        ok_now;

  // Fixed answer bytes that must hold a given value: type, class, rdlength.
  always_comb begin
    case (idx_r)
      4'd2, 4'd4, 4'd10: mismatch = (data_byte != 8'd0);
      4'd3, 4'd5:        mismatch = (data_byte != 8'd1);
      4'd11:             mismatch = (data_byte != 8'd4);
      default:           mismatch = 1'b0;
    endcase
  end

  assign ok_now = fields_ok_r & ~mismatch;

  // Next state for the current byte, before rearming at packet end.
  always_comb begin
    phase_upd     = phase_r;
    idx_upd       = idx_r;
    qcount_upd    = qcount_r;
    acount_upd    = acount_r;
    qleft_upd     = qleft_r;
    fields_ok_upd = fields_ok_r;
    addr_upd      = addr_r;
    case (phase_r)
      PH_HEADER: begin
        case (idx_r)
          4'd4:    qcount_upd = {data_byte, 8'h00};
          4'd5:    qcount_upd = {qcount_r[15:8], data_byte};
          4'd6:    acount_upd = {data_byte, 8'h00};
          4'd7:    acount_upd = {acount_r[15:8], data_byte};
          default: ;
        endcase
        if (idx_r == HEADER_LAST) begin
          phase_upd = (qcount_r == 16'd0 || acount_r == 16'd0) ? PH_ZERO : PH_QNAME;
          qleft_upd = qcount_r;
          idx_upd   = 4'd0;
        end else begin
          idx_upd = idx_r + 4'd1;
        end
      end
      PH_QNAME: begin
        if (data_byte == 8'd0) begin
          phase_upd = PH_QTAIL;
          idx_upd   = 4'd0;
        end
      end
      PH_QTAIL: begin
        if (idx_r == QTAIL_LAST) begin
          qleft_upd = qleft_r - 16'd1;
          idx_upd   = 4'd0;
          phase_upd = (qleft_r != 16'd1) ? PH_QNAME : PH_ANSWER;
        end else begin
          idx_upd = idx_r + 4'd1;
        end
      end
      PH_ANSWER: begin
        fields_ok_upd = ok_now;
        if (idx_r == ANSWER_LAST) begin
          phase_upd = ok_now ? PH_RDATA : PH_BADREC;
          idx_upd   = 4'd0;
        end else begin
          idx_upd = idx_r + 4'd1;
        end
      end
      PH_RDATA: begin
        addr_upd[idx_r[1:0]*8 +: 8] = addr_r[idx_r[1:0]*8 +: 8] | data_byte;
        if (idx_r == RDATA_LAST) begin
          phase_upd = PH_FOUND;
          idx_upd   = 4'd0;
        end else begin
          idx_upd = idx_r + 4'd1;
        end
      end
      default: ;
    endcase
  end

  // The final byte of a packet rearms the parser for the next one.
  always_comb begin
    if (last) begin
      phase_nxt     = PH_HEADER;
      idx_nxt       = 4'd0;
      qcount_nxt    = 16'd0;
      acount_nxt    = 16'd0;
      qleft_nxt     = 16'd0;
      fields_ok_nxt = 1'b1;
      addr_nxt      = 32'd0;
    end else begin
      phase_nxt     = phase_upd;
      idx_nxt       = idx_upd;
      qcount_nxt    = qcount_upd;
      acount_nxt    = acount_upd;
      qleft_nxt     = qleft_upd;
      fields_ok_nxt = fields_ok_upd;
      addr_nxt      = addr_upd;
    end
  end

  // Result of the packet, judged on the state after its final byte.
  always_comb begin
    res.found   = 1'b0;
    res.address = 32'd0;
    if (source_port != server_port) begin
      res.status = ST_WRONG_PORT;
    end else begin
      case (phase_upd)
        PH_HEADER: res.status = ST_SHORT_HDR;
        PH_ZERO:   res.status = ST_ZERO_COUNT;
        PH_BADREC: res.status = ST_BAD_RECORD;
        PH_FOUND: begin
          res.status  = ST_OK;
          res.found   = 1'b1;
          res.address = addr_upd;
        end
        default:   res.status = ST_TRUNCATED;
      endcase
    end
  end

  // Parse state registers advance on every accepted byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      idx_r       <= 4'd0;
      qcount_r    <= 16'd0;
      acount_r    <= 16'd0;
      qleft_r     <= 16'd0;
      fields_ok_r <= 1'b1;
      addr_r      <= 32'd0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      qcount_r    <= qcount_nxt;
      acount_r    <= acount_nxt;
      qleft_r     <= qleft_nxt;
      fields_ok_r <= fields_ok_nxt;
      addr_r      <= addr_nxt;
    end
  end

endmodule

@@ rtl/dns_a_record_response_parser.sv @@
// DNS A-record response parser, top level. Takes one payload byte per cycle.
// The result of a packet is registered into the output register, or into the skid entry while that is held.
// Throughput: one byte per cycle; a result register plus one skid entry decouple
// the output, so input stalls only when both hold undelivered results.
// Reset (synchronous, rst_n low) rearms the parser, empties the output and sets
// server_port to 53. Depends on dnsar_pkg, the channel interfaces and dnsar_core.
module dns_a_record_response_parser (
  input  logic         clk,
  input  logic         rst_n,
  dnsar_in_if.sink     in_ch,
  dnsar_out_if.source  out_ch,
  dnsar_cfg_if.sink    cfg_ch
);
  import dnsar_pkg::*;

  logic [15:0] server_port_r;
  result_t     res;
  result_t     out_res_r, out_res_nxt;
  result_t     skid_res_r, skid_res_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  logic        in_acc;
  logic        push;
  logic        pop;

  // Configuration transactions are always taken.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      server_port_r <= SERVER_PORT_RST;
    end else if (cfg_ch.valid) begin
      server_port_r <= cfg_ch.server_port;
    end
  end

  // Input is held off only when the skid entry is occupied.
  assign in_ch.ready = ~skid_valid_r;
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign push        = in_acc & in_ch.last;
  assign pop         = out_valid_r & out_ch.ready;

  dnsar_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_acc),
    .data_byte   (in_ch.data_byte),
    .source_port (in_ch.source_port),
    .last        (in_ch.last),
    .server_port (server_port_r),
    .res         (res)
  );

  // Output register with one skid entry behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || pop) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = push;
        skid_res_nxt   = res;
      end else begin
        out_valid_nxt = push;
        out_res_nxt   = res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.found   = out_res_r.found;
  assign out_ch.address = out_res_r.address;
  assign out_ch.status  = out_res_r.status;

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry valid while output register empty");

  // Found is set exactly for the ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_res_r.found == (out_res_r.status == ST_OK)))
    else $error("found flag disagrees with status");

  // A failed parse reports a zero address.
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.found) |-> (out_res_r.address == 32'd0))
    else $error("nonzero address without found");

  // A result that is waiting and a new final byte both land somewhere.
  a_no_loss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready && push) |=> skid_valid_r)
    else $error("result dropped while output stalled");
`endif

endmodule
